[sv/slac_pkg.sv]
package slac_pkg;

  // Access operation codes
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd3;

  // Outcome codes of a data access
  localparam int unsigned OUTCOME_W = 2;
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // Statistics counters
  localparam int unsigned CNT_W = 32;

  // Configuration registers
  localparam int unsigned SET_BITS_W   = 3;
  localparam int unsigned BLOCK_BITS_W = 6;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned PADDR_W      = 4;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned REG_IDX_W    = 2;
  localparam logic [REG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write a zero row during the post-reset sweep
    logic lookup;  // take the word, read its set
    logic commit;  // write back the set, load the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last row
    logic is_fetch;    // offered word is an instruction fetch
    logic out_free;    // result register can take a new word
  } dp_status_t;

endpackage

[sv/slac_req_if.sv]
interface slac_req_if #(
  parameter int ADDR_WIDTH = 48
);
  logic                         valid;
  logic                         ready;
  logic [slac_pkg::OP_W-1:0]    operation;
  logic [ADDR_WIDTH-1:0]        address;

  modport source (output valid, output operation, output address, input ready);
  modport sink (input valid, input operation, input address, output ready);
endinterface

[sv/slac_rsp_if.sv]
interface slac_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [slac_pkg::OUTCOME_W-1:0]    outcome;
  logic                              second_hit;
  logic [slac_pkg::CNT_W-1:0]        hits_total;
  logic [slac_pkg::CNT_W-1:0]        misses_total;
  logic [slac_pkg::CNT_W-1:0]        evictions_total;

  modport source (output valid, output outcome, output second_hit, output hits_total,
                  output misses_total, output evictions_total, input ready);
  modport sink (input valid, input outcome, input second_hit, input hits_total,
                input misses_total, input evictions_total, output ready);
endinterface

[sv/set_assoc_lru_cache_sim.sv]
// Set-associative cache hit/miss model with LRU replacement. Each request word
// carries an operation and a byte address; loads, stores and modifies return one
// response word with the outcome (hit, fill of a free way, or eviction), a
// second-hit flag for modifies and the running saturating hit, miss and eviction
// totals. Instruction fetches are accepted and give no response. A data access
// reads the whole set in its accept cycle (all ways in one row of the set RAM);
// in the access state the datapath compares tags, picks the way, updates the
// recency ranks and writes the row back; the response register decouples
// the output, and the access state waits only while a previous response is
// still held. After reset a clearing sweep writes one set per cycle through
// all 2^MAX_SET_BITS sets (64 by default) before the first request is accepted;
// configuration writes are taken at any time but belong to idle periods.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  slac_req_if.sink                       req_i,
  slac_rsp_if.source                     rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slac_pkg::PADDR_W-1:0]   paddr,
  input  logic [slac_pkg::PDATA_W-1:0]   pwdata,
  output logic [slac_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // configuration registers
  logic [slac_pkg::SET_BITS_W-1:0]   set_bits_q;
  logic [slac_pkg::BLOCK_BITS_W-1:0] block_bits_q;
  logic [slac_pkg::WAYS_W-1:0]       ways_in_use_q;
  logic [slac_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[slac_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= '0;
      block_bits_q  <= '0;
      ways_in_use_q <= slac_pkg::WAYS_W'(1);
    end else if (reg_wr) begin
      unique case (reg_idx)
        slac_pkg::REG_SET_BITS:    set_bits_q    <= pwdata[slac_pkg::SET_BITS_W-1:0];
        slac_pkg::REG_BLOCK_BITS:  block_bits_q  <= pwdata[slac_pkg::BLOCK_BITS_W-1:0];
        slac_pkg::REG_WAYS_IN_USE: ways_in_use_q <= pwdata[slac_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      slac_pkg::REG_SET_BITS:    prdata = slac_pkg::PDATA_W'(set_bits_q);
      slac_pkg::REG_BLOCK_BITS:  prdata = slac_pkg::PDATA_W'(block_bits_q);
      slac_pkg::REG_WAYS_IN_USE: prdata = slac_pkg::PDATA_W'(ways_in_use_q);
      default:                   prdata = '0;
    endcase
  end

  // controller and datapath
  slac_pkg::ctrl_cmd_t  cmd;
  slac_pkg::dp_status_t status;
  logic                 in_ready;

  slac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  slac_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .set_bits_i        (set_bits_q),
    .block_bits_i      (block_bits_q),
    .ways_in_use_i     (ways_in_use_q),
    .operation_i       (req_i.operation),
    .address_i         (req_i.address),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .outcome_o         (rsp_o.outcome),
    .second_hit_o      (rsp_o.second_hit),
    .hits_total_o      (rsp_o.hits_total),
    .misses_total_o    (rsp_o.misses_total),
    .evictions_total_o (rsp_o.evictions_total)
  );

`ifndef NO_ASSERTIONS
  // at most one datapath command per cycle
  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.lookup, cmd.commit}))
    else $error("overlapping datapath commands");

  // write-back never overruns a held response
  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> status.out_free)
    else $error("commit while response register is full");

  // no new request while a set lookup is in flight
  a_lookup_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.lookup |=> !in_ready)
    else $error("request accepted during access cycle");

  // a response appears only after a write-back
  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.commit))
    else $error("response without a committed access");
`endif

endmodule

[sv/slac_ram.sv]
module slac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/slac_ctrl.sv]
module slac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  slac_pkg::dp_status_t status_i,
  output slac_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_ACCESS = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // fetches are taken and dropped here
        if (in_valid_i && !status_i.is_fetch) begin
          cmd_o.lookup = 1'b1;
          state_d      = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        // hold the set read until the result slot frees up
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/slac_dp.sv]
module slac_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slac_pkg::ctrl_cmd_t                 cmd_i,
  output slac_pkg::dp_status_t                status_o,
  input  logic [slac_pkg::SET_BITS_W-1:0]     set_bits_i,
  input  logic [slac_pkg::BLOCK_BITS_W-1:0]   block_bits_i,
  input  logic [slac_pkg::WAYS_W-1:0]         ways_in_use_i,
  input  logic [slac_pkg::OP_W-1:0]           operation_i,
  input  logic [ADDR_WIDTH-1:0]               address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [slac_pkg::OUTCOME_W-1:0]      outcome_o,
  output logic                                second_hit_o,
  output logic [slac_pkg::CNT_W-1:0]          hits_total_o,
  output logic [slac_pkg::CNT_W-1:0]          misses_total_o,
  output logic [slac_pkg::CNT_W-1:0]          evictions_total_o
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int LINE_W   = 1 + ADDR_WIDTH + RANK_W;
  localparam int ROW_W    = MAX_WAYS * LINE_W;
  localparam int RANK_MAX = MAX_WAYS - 1;
  localparam int SH_W     = 7;
  localparam int CNT_W    = slac_pkg::CNT_W;

  // effective geometry and address split
  logic [slac_pkg::SET_BITS_W-1:0] s_eff;
  logic [WC_W-1:0]                 ways_eff;
  logic [SH_W-1:0]                 sh;
  logic [SET_AW-1:0]               set_mask;
  logic [SET_AW-1:0]               set_idx;
  logic [ADDR_WIDTH-1:0]           tag;

  always_comb begin
    if (int'(set_bits_i) > MAX_SET_BITS) begin
      s_eff = slac_pkg::SET_BITS_W'(MAX_SET_BITS);
    end else begin
      s_eff = set_bits_i;
    end
    if (ways_in_use_i == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_in_use_i) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_in_use_i);
    end
    sh       = SH_W'(s_eff) + SH_W'(block_bits_i);
    set_mask = SET_AW'((1 << s_eff) - 1);
    set_idx  = SET_AW'(address_i >> block_bits_i) & set_mask;
    // shifts past the address width leave zero
    tag      = address_i >> sh;
  end

  // word held for the access cycle
  logic [slac_pkg::OP_W-1:0] op_q;
  logic [SET_AW-1:0]         set_q;
  logic [ADDR_WIDTH-1:0]     tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      op_q  <= operation_i;
      set_q <= set_idx;
      tag_q <= tag;
    end
  end

  // post-reset sweep pointer
  logic [SET_AW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + SET_AW'(1);
    end
  end

  // set storage: one row holds every way of a set
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_new;

  slac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear | cmd_i.commit),
    .waddr_i (cmd_i.clear ? clr_idx_q : set_q),
    .wdata_i (cmd_i.clear ? '0 : row_new),
    .re_i    (cmd_i.lookup),
    .raddr_i (set_idx),
    .rdata_o (row_rd)
  );

  // unpack the ways
  logic                  vld    [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tagw   [MAX_WAYS];
  logic [RANK_W-1:0]     rank   [MAX_WAYS];
  logic                  in_use [MAX_WAYS];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w]    = row_rd[w*LINE_W + LINE_W - 1];
      tagw[w]   = row_rd[w*LINE_W + RANK_W +: ADDR_WIDTH];
      rank[w]   = row_rd[w*LINE_W +: RANK_W];
      in_use[w] = (w < int'(ways_eff));
    end
  end

  // hit search, free way, LRU victim, rank update
  logic              hit;
  logic              fill;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  vic_way;
  logic [WAY_W-1:0]  sel_way;
  logic [RANK_W-1:0] limit;
  logic              no_limit;
  logic              age;

  always_comb begin
    hit      = 1'b0;
    fill     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    // downward scan keeps the lowest-numbered match
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && vld[w] && (tagw[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !vld[w]) begin
        fill     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    // oldest way, lowest on a tie
    vic_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rank[w] > rank[vic_way])) begin
        vic_way = WAY_W'(w);
      end
    end
    if (hit) begin
      sel_way  = hit_way;
      limit    = rank[hit_way];
      no_limit = 1'b0;
    end else if (fill) begin
      sel_way  = free_way;
      limit    = '0;
      no_limit = 1'b1;
    end else begin
      sel_way  = vic_way;
      limit    = rank[vic_way];
      no_limit = 1'b0;
    end
    age = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        row_new[w*LINE_W +: LINE_W] = {1'b1, tag_q, {RANK_W{1'b0}}};
      end else begin
        age = in_use[w] && vld[w] && (no_limit || (rank[w] < limit)) &&
              (int'(rank[w]) < RANK_MAX);
        row_new[w*LINE_W +: LINE_W] = {vld[w], tagw[w],
                                      age ? rank[w] + RANK_W'(1) : rank[w]};
      end
    end
  end

  // saturating statistics
  logic [1:0]     hit_inc;
  logic [CNT_W:0] hit_sum;
  logic [CNT_W:0] miss_sum;
  logic [CNT_W:0] evict_sum;
  logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;

  always_comb begin
    hit_inc   = 2'(hit) + 2'(op_q == slac_pkg::OP_MODIFY);
    hit_sum   = {1'b0, hit_cnt_q} + (CNT_W+1)'(hit_inc);
    miss_sum  = {1'b0, miss_cnt_q} + (CNT_W+1)'(!hit);
    evict_sum = {1'b0, evict_cnt_q} + (CNT_W+1)'(!hit && !fill);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      hit_cnt_q   <= hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
      miss_cnt_q  <= miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
      evict_cnt_q <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
    end
  end

  // result register; counters move when a result is loaded into it
  logic                             out_valid_q;
  logic [slac_pkg::OUTCOME_W-1:0]   outcome_q;
  logic                             second_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      outcome_q    <= hit ? slac_pkg::OUT_HIT :
                      fill ? slac_pkg::OUT_FILL : slac_pkg::OUT_EVICT;
      second_hit_q <= (op_q == slac_pkg::OP_MODIFY);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign second_hit_o      = second_hit_q;
  assign hits_total_o      = hit_cnt_q;
  assign misses_total_o    = miss_cnt_q;
  assign evictions_total_o = evict_cnt_q;

  assign status_o.clear_last = (clr_idx_q == SET_AW'(NUM_SETS - 1));
  assign status_o.is_fetch   = (operation_i == slac_pkg::OP_FETCH);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule
